// ===== design/pst_pkg.sv =====
// ---------------------------------------------------------------------------
// pst_pkg: shared types and codes for the process slot table
// Command, state and status codes, the token that walks the cell chain,
// and the five-state transition check.
// ---------------------------------------------------------------------------
package pst_pkg;

  localparam int unsigned PstSlotsDefault = 16;

  localparam int unsigned IdW    = 16;
  localparam int unsigned StateW = 3;
  localparam int unsigned CmdW   = 2;
  localparam int unsigned StatW  = 2;

  // commands
  localparam logic [CmdW-1:0] CmdCreate = 2'd0;
  localparam logic [CmdW-1:0] CmdChange = 2'd1;
  localparam logic [CmdW-1:0] CmdLookup = 2'd2;

  // process states
  localparam logic [StateW-1:0] StNew        = 3'd0;
  localparam logic [StateW-1:0] StReady      = 3'd1;
  localparam logic [StateW-1:0] StRunning    = 3'd2;
  localparam logic [StateW-1:0] StSleeping   = 3'd3;
  localparam logic [StateW-1:0] StTerminated = 3'd4;

  // result status
  localparam logic [StatW-1:0] StatOk      = 2'd0;
  localparam logic [StatW-1:0] StatFull    = 2'd1;
  localparam logic [StatW-1:0] StatUnknown = 2'd2;
  localparam logic [StatW-1:0] StatInvalid = 2'd3;

  // command plus partial result, handed from cell to cell
  typedef struct packed {
    logic [CmdW-1:0]   cmd;
    logic [IdW-1:0]    target_id;
    logic [StateW-1:0] want;
    logic [15:0]       base;
    logic [15:0]       limit;
    logic [15:0]       pc;
    logic [IdW-1:0]    new_id;
    logic              done;
    logic [StatW-1:0]  status;
    logic [IdW-1:0]    res_id;
    logic [StateW-1:0] res_state;
    logic [15:0]       res_base;
    logic [15:0]       res_limit;
    logic [15:0]       res_pc;
  } pst_token_t;

  function automatic logic move_allowed(logic [StateW-1:0] from, logic [StateW-1:0] to);
    logic ok;
    ok = 1'b0;
    if (from == to) begin
      ok = 1'b1;
    end else begin
      case (from)
        StNew:      ok = (to == StReady) || (to == StTerminated);
        StReady:    ok = (to == StRunning) || (to == StSleeping) || (to == StTerminated);
        StRunning:  ok = (to == StReady) || (to == StSleeping) || (to == StTerminated);
        StSleeping: ok = (to == StReady) || (to == StTerminated);
        default:    ok = 1'b0;
      endcase
    end
    return ok;
  endfunction

endpackage

// ===== design/pst_cell.sv =====
// ---------------------------------------------------------------------------
// pst_cell: one slot of the process table
// Holds one entry and a token stage. An unclaimed token is served by the
// first cell that can take it; the cell then marks the token done.
// ---------------------------------------------------------------------------
module pst_cell
  import pst_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       tok_valid_i,
  input  pst_token_t tok_i,
  output logic       tok_valid_o,
  output pst_token_t tok_o
);

  logic              in_use_q, in_use_d;
  logic [IdW-1:0]    id_q, id_d;
  logic [StateW-1:0] state_q, state_d;
  logic [15:0]       base_q, base_d;
  logic [15:0]       limit_q, limit_d;
  logic [15:0]       pc_q, pc_d;
  logic              tok_valid_q;
  pst_token_t        tok_q, tok_d;

  logic free;
  logic hit;
  logic act;

  assign free = !in_use_q || (state_q == StTerminated);
  assign hit  = in_use_q && (id_q == tok_i.target_id);
  assign act  = tok_valid_i && !tok_i.done;

  always_comb begin
    in_use_d = in_use_q;
    id_d     = id_q;
    state_d  = state_q;
    base_d   = base_q;
    limit_d  = limit_q;
    pc_d     = pc_q;
    tok_d    = tok_i;
    if (act) begin
      unique case (tok_i.cmd)
        CmdCreate: begin
          if (free) begin
            in_use_d        = 1'b1;
            id_d            = tok_i.new_id;
            state_d         = StNew;
            base_d          = tok_i.base;
            limit_d         = tok_i.limit;
            pc_d            = tok_i.pc;
            tok_d.done      = 1'b1;
            tok_d.status    = StatOk;
            tok_d.res_id    = tok_i.new_id;
            tok_d.res_state = StNew;
            tok_d.res_base  = tok_i.base;
            tok_d.res_limit = tok_i.limit;
            tok_d.res_pc    = tok_i.pc;
          end
        end
        CmdChange, CmdLookup: begin
          if (hit) begin
            tok_d.done      = 1'b1;
            tok_d.status    = StatOk;
            tok_d.res_id    = id_q;
            tok_d.res_state = state_q;
            tok_d.res_base  = base_q;
            tok_d.res_limit = limit_q;
            tok_d.res_pc    = pc_q;
            if (tok_i.cmd == CmdChange) begin
              if (move_allowed(state_q, tok_i.want)) begin
                state_d         = tok_i.want;
                tok_d.res_state = tok_i.want;
              end else begin
                tok_d.status = StatInvalid;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q    <= 1'b0;
      id_q        <= '0;
      state_q     <= StTerminated;
      tok_valid_q <= 1'b0;
    end else begin
      in_use_q    <= in_use_d;
      id_q        <= id_d;
      state_q     <= state_d;
      tok_valid_q <= tok_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q  <= base_d;
    limit_q <= limit_d;
    pc_q    <= pc_d;
    tok_q   <= tok_d;
  end

  assign tok_valid_o = tok_valid_q;
  assign tok_o       = tok_q;

endmodule

// ===== design/process_slot_table_unit.sv =====
// ---------------------------------------------------------------------------
// process_slot_table_unit: process control table over a chain of slot cells
// A command enters as a token, walks the slot cells one per cycle and
// leaves with its result; the lowest-numbered slot that fits serves it.
// ---------------------------------------------------------------------------
//   channel | handshake                | payload
//   --------+--------------------------+-------------------------------------
//   in      | in_valid_i / in_ready_o  | command, target_id, new_state,
//           |                          | mem_base, mem_limit, start_pc
//   out     | out_valid_o / out_ready_i| status, result_id, result_state,
//           |                          | result_base, result_limit, result_pc
//
// A beat's result is registered in the entry stage, in each slot cell and in
// the output register before it is valid. One command is in flight at a
// time, so the next input beat is taken the cycle after the result beat
// leaves. Reset clears every slot at once: no clearing pass. A stalled result
// holds the output register and the input side.
// ---------------------------------------------------------------------------
module process_slot_table_unit
  import pst_pkg::*;
#(
  parameter int unsigned SLOTS = PstSlotsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [CmdW-1:0]   command_i,
  input  logic [IdW-1:0]    target_id_i,
  input  logic [StateW-1:0] new_state_i,
  input  logic [15:0]       mem_base_i,
  input  logic [15:0]       mem_limit_i,
  input  logic [15:0]       start_pc_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [StatW-1:0]  status_o,
  output logic [IdW-1:0]    result_id_o,
  output logic [StateW-1:0] result_state_o,
  output logic [15:0]       result_base_o,
  output logic [15:0]       result_limit_o,
  output logic [15:0]       result_pc_o
);

  logic           busy_q, busy_d;
  logic [IdW-1:0] next_id_q, next_id_d;
  logic           out_valid_q, out_valid_d;
  pst_token_t     out_q, out_d;
  logic           in_fire;
  logic           out_fire;

  logic           entry_valid_q;
  pst_token_t     entry_q, entry_d;

  logic       tok_valid [SLOTS+1];
  pst_token_t tok       [SLOTS+1];

  assign in_ready_o = !busy_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_fire   = out_valid_q && out_ready_i;

  always_comb begin
    entry_d           = '0;
    entry_d.cmd       = command_i;
    entry_d.target_id = target_id_i;
    entry_d.want      = new_state_i;
    entry_d.base      = mem_base_i;
    entry_d.limit     = mem_limit_i;
    entry_d.pc        = start_pc_i;
    entry_d.new_id    = next_id_q;
  end

  assign tok_valid[0] = entry_valid_q;
  assign tok[0]       = entry_q;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    pst_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .tok_valid_i(tok_valid[g]),
      .tok_i      (tok[g]),
      .tok_valid_o(tok_valid[g+1]),
      .tok_o      (tok[g+1])
    );
  end

  // finish the token leaving the chain; unclaimed tokens report zero results and an error status
  always_comb begin
    busy_d      = busy_q;
    next_id_d   = next_id_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (in_fire) begin
      busy_d = 1'b1;
    end
    if (out_fire) begin
      out_valid_d = 1'b0;
      busy_d      = 1'b0;
    end
    if (tok_valid[SLOTS]) begin
      out_valid_d = 1'b1;
      out_d       = tok[SLOTS];
      if (!tok[SLOTS].done) begin
        out_d.res_id    = '0;
        out_d.res_state = '0;
        out_d.res_base  = '0;
        out_d.res_limit = '0;
        out_d.res_pc    = '0;
        unique case (tok[SLOTS].cmd)
          CmdCreate:            out_d.status = StatFull;
          CmdChange, CmdLookup: out_d.status = StatUnknown;
          default:              out_d.status = StatInvalid;
        endcase
      end else if (tok[SLOTS].cmd == CmdCreate) begin
        // advance the id counter, skipping zero
        next_id_d = next_id_q + IdW'(1);
        if (next_id_d == '0) begin
          next_id_d = IdW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q        <= 1'b0;
      next_id_q     <= IdW'(1);
      out_valid_q   <= 1'b0;
      entry_valid_q <= 1'b0;
    end else begin
      busy_q        <= busy_d;
      next_id_q     <= next_id_d;
      out_valid_q   <= out_valid_d;
      entry_valid_q <= in_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      entry_q <= entry_d;
    end
    out_q <= out_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_q.status;
  assign result_id_o    = out_q.res_id;
  assign result_state_o = out_q.res_state;
  assign result_base_o  = out_q.res_base;
  assign result_limit_o = out_q.res_limit;
  assign result_pc_o    = out_q.res_pc;

endmodule
